>>> src/wlst_pkg.sv
// shared types, codes and constants of the wireless link statistics table
package wlst_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int MAC_W   = 48;
	localparam int CNT_W   = 32;
	localparam int SEQ_W   = 12;
	localparam int IDX_W   = 6;
	localparam int IN_DW   = 224;
	localparam int OUT_DW  = 64;

	// request kinds
	localparam logic [1:0] REQ_FRAME = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// result status codes
	localparam logic [2:0] STS_UPDATED  = 3'd0;
	localparam logic [2:0] STS_FILTERED = 3'd1;
	localparam logic [2:0] STS_FULL     = 3'd2;
	localparam logic [2:0] STS_READ     = 3'd3;
	localparam logic [2:0] STS_CLEARED  = 3'd4;

	// frame types
	localparam logic [1:0] FT_MGMT = 2'd0;
	localparam logic [1:0] FT_CTRL = 2'd1;
	localparam logic [1:0] FT_DATA = 2'd2;
	localparam logic [1:0] FT_RSVD = 2'd3;

	localparam logic [3:0] SUB_DISASSOC = 4'd10;
	localparam logic [3:0] SUB_DEAUTH   = 4'd12;

	// read selects
	localparam logic [3:0] SEL_PACKETS  = 4'd0;
	localparam logic [3:0] SEL_RETRIES  = 4'd1;
	localparam logic [3:0] SEL_MGMT     = 4'd2;
	localparam logic [3:0] SEL_CONTROL  = 4'd3;
	localparam logic [3:0] SEL_DISASSOC = 4'd4;
	localparam logic [3:0] SEL_DEAUTH   = 4'd5;
	localparam logic [3:0] SEL_DATA     = 4'd6;
	localparam logic [3:0] SEL_BYTES    = 4'd7;
	localparam logic [3:0] SEL_SIGNAL   = 4'd8;
	localparam logic [3:0] SEL_NOISE    = 4'd9;
	localparam logic [3:0] SEL_SEQ      = 4'd10;
	localparam logic [3:0] SEL_AP       = 4'd11;
	localparam logic [3:0] SEL_CLIENT   = 4'd12;
	localparam logic [3:0] SEL_BSSID    = 4'd13;
	localparam logic [3:0] SEL_DIR      = 4'd14;

	typedef struct packed {
		logic [MAC_W-1:0] ap;
		logic [MAC_W-1:0] client;
		logic [MAC_W-1:0] bssid;
		logic [1:0]       dir;
	} key_t;

	typedef struct packed {
		logic [CNT_W-1:0] packets;
		logic [CNT_W-1:0] retries;
		logic [CNT_W-1:0] mgmt;
		logic [CNT_W-1:0] control;
		logic [CNT_W-1:0] disassoc;
		logic [CNT_W-1:0] deauth;
		logic [CNT_W-1:0] data;
		logic [CNT_W-1:0] bytes;
		logic [CNT_W-1:0] signal;
		logic [CNT_W-1:0] noise;
		logic [SEQ_W-1:0] last_seq;
	} cnt_t;

	typedef struct packed {
		logic [1:0]  ftype;
		logic [3:0]  sub;
		logic        retry;
		logic [11:0] seq;
		logic [15:0] len;
		logic [7:0]  rssi;
		logic [7:0]  noise;
	} frm_t;

	localparam int KEY_W = $bits(key_t);
	localparam int CNT_REC_W = $bits(cnt_t);

endpackage

>>> src/wifi_link_stats_table.sv
// wireless link statistics table: top level
//
// s_* takes one request at a time: tuser is the request kind (frame update,
// read one value, clear table), tdata the header fields. m_* returns exactly
// one result per request: tuser is the status, tdata index, flags and value.
// cfg_* writes the data-frame filter bit; it is always ready.
// Entries are allocated in order, so a fill count marks which are valid and a
// clear takes effect at once; keys and counters sit in two rams.
// A frame update walks the key ram one entry a cycle (one compare per cycle,
// pipelined behind the ram read), then reads, updates and writes back the
// counter record. Reads, clears and ignored kinds do not search.
// The next request is taken as soon as the result sits in the output
// register, even if the receiver has not taken it yet; a stalled receiver
// holds the result and blocks the block only once a second one is ready.
// After reset the table is empty, the data filter is on and no ram clearing
// is run.
module wifi_link_stats_table #(
	parameter int TABLE_ENTRIES = wlst_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// fc_byte0, fc_byte1, addr_one, addr_two, addr_three, seq_control,
	// frame_length, rssi, noise_level, read_index, read_select, zero pad
	input  logic [wlst_pkg::IN_DW-1:0]  s_tdata,
	// req_type
	input  logic [1:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// entry_index, new_entry, link_direction, read_value, zero pad
	output logic [wlst_pkg::OUT_DW-1:0] m_tdata,
	// status
	output logic [2:0]                  m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam int XW = (UW > wlst_pkg::IDX_W) ? UW : wlst_pkg::IDX_W;
	localparam logic [UW-1:0] FULL_CNT = UW'(TABLE_ENTRIES);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_UPD_RD = 3'd2;
	localparam logic [2:0] S_UPD_WR = 3'd3;
	localparam logic [2:0] S_RD_RD  = 3'd4;
	localparam logic [2:0] S_RD_VAL = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0] state_q;
	logic       data_filter_q;
	logic [UW-1:0] used_q;
	logic [UW-1:0] ptr_q;
	logic          cmp_s1;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] slot_q;
	logic          fresh_q;
	wlst_pkg::key_t key_q;
	wlst_pkg::frm_t frm_q;
	logic [5:0]    ri_q;
	logic [3:0]    rsel_q;
	logic          rd_ok_q;

	logic [2:0]    res_sts_q;
	logic [5:0]    res_idx_q;
	logic          res_new_q;
	logic [1:0]    res_dir_q;
	logic [47:0]   res_val_q;

	logic          m_tvalid_q;
	logic [2:0]    out_sts_q;
	logic [5:0]    out_idx_q;
	logic          out_new_q;
	logic [1:0]    out_dir_q;
	logic [47:0]   out_val_q;

	// input field views
	logic [7:0]  in_fc0, in_fc1;
	logic [47:0] in_a1, in_a2, in_a3;
	wlst_pkg::key_t in_key;
	wlst_pkg::frm_t in_frm;
	logic        in_filtered;

	assign in_fc0 = s_tdata[7:0];
	assign in_fc1 = s_tdata[15:8];
	assign in_a1  = s_tdata[63:16];
	assign in_a2  = s_tdata[111:64];
	assign in_a3  = s_tdata[159:112];

	always_comb begin
		case (in_fc1[1:0])
			2'd0: in_key = '{ap: in_a1, client: in_a2, bssid: in_a3, dir: 2'd0};
			2'd1: in_key = '{ap: in_a3, client: in_a2, bssid: in_a1, dir: 2'd2};
			2'd2: in_key = '{ap: in_a3, client: in_a1, bssid: in_a2, dir: 2'd1};
			default: in_key = '{ap: in_a2, client: in_a1, bssid: in_a3, dir: 2'd3};
		endcase
		in_frm.ftype = in_fc0[3:2];
		in_frm.sub   = in_fc0[7:4];
		in_frm.retry = in_fc1[3];
		in_frm.seq   = s_tdata[175:164];
		in_frm.len   = s_tdata[191:176];
		in_frm.rssi  = s_tdata[199:192];
		in_frm.noise = s_tdata[207:200];
		in_filtered  = data_filter_q && (in_frm.ftype != wlst_pkg::FT_DATA);
	end

	// rams
	logic [AW-1:0] ri_addr;
	logic          ri_ok;
	logic          srch_re;
	logic          key_we, key_re, cnt_we, cnt_re;
	logic [AW-1:0] key_raddr, cnt_raddr;
	logic [wlst_pkg::KEY_W-1:0]     key_rdata;
	logic [wlst_pkg::CNT_REC_W-1:0] cnt_rdata;
	wlst_pkg::key_t key_rd;
	wlst_pkg::cnt_t cnt_rd, cnt_new;
	logic           hit;

	assign ri_addr   = AW'(XW'(ri_q));
	assign ri_ok     = XW'(ri_q) < XW'(used_q);
	assign srch_re   = (state_q == S_SEARCH) && (ptr_q < used_q);
	assign key_re    = srch_re || (state_q == S_RD_RD);
	assign key_raddr = (state_q == S_SEARCH) ? AW'(ptr_q) : ri_addr;
	assign key_we    = (state_q == S_UPD_WR) && fresh_q;
	assign cnt_re    = (state_q == S_UPD_RD) || (state_q == S_RD_RD);
	assign cnt_raddr = (state_q == S_UPD_RD) ? slot_q : ri_addr;
	assign cnt_we    = (state_q == S_UPD_WR);
	assign key_rd    = key_rdata;
	assign cnt_rd    = cnt_rdata;
	assign hit       = cmp_s1 && (key_rd == key_q);

	wlst_ram #(.WIDTH(wlst_pkg::KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot_q),
		.wdata (key_q),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	wlst_ram #(.WIDTH(wlst_pkg::CNT_REC_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (slot_q),
		.wdata (cnt_new),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	wlst_update u_update (
		.base  (cnt_rd),
		.fresh (fresh_q),
		.frm   (frm_q),
		.upd   (cnt_new)
	);

	// read value selection
	logic [47:0] sel_val;
	always_comb begin
		case (rsel_q)
			wlst_pkg::SEL_PACKETS:  sel_val = 48'(cnt_rd.packets);
			wlst_pkg::SEL_RETRIES:  sel_val = 48'(cnt_rd.retries);
			wlst_pkg::SEL_MGMT:     sel_val = 48'(cnt_rd.mgmt);
			wlst_pkg::SEL_CONTROL:  sel_val = 48'(cnt_rd.control);
			wlst_pkg::SEL_DISASSOC: sel_val = 48'(cnt_rd.disassoc);
			wlst_pkg::SEL_DEAUTH:   sel_val = 48'(cnt_rd.deauth);
			wlst_pkg::SEL_DATA:     sel_val = 48'(cnt_rd.data);
			wlst_pkg::SEL_BYTES:    sel_val = 48'(cnt_rd.bytes);
			wlst_pkg::SEL_SIGNAL:   sel_val = 48'(cnt_rd.signal);
			wlst_pkg::SEL_NOISE:    sel_val = 48'(cnt_rd.noise);
			wlst_pkg::SEL_SEQ:      sel_val = 48'(cnt_rd.last_seq);
			wlst_pkg::SEL_AP:       sel_val = key_rd.ap;
			wlst_pkg::SEL_CLIENT:   sel_val = key_rd.client;
			wlst_pkg::SEL_BSSID:    sel_val = key_rd.bssid;
			wlst_pkg::SEL_DIR:      sel_val = 48'(key_rd.dir);
			default:                sel_val = '0;
		endcase
	end

	logic out_free;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			data_filter_q <= 1'b1;
			used_q        <= '0;
			cmp_s1        <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				data_filter_q <= cfg_data;
			end
			if (state_q == S_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cmp_s1 <= 1'b0;
					if (s_tvalid) begin
						case (s_tuser)
							wlst_pkg::REQ_CLEAR: begin
								used_q  <= '0;
								state_q <= S_RESP;
							end
							wlst_pkg::REQ_READ: begin
								state_q <= S_RD_RD;
							end
							wlst_pkg::REQ_FRAME: begin
								state_q <= in_filtered ? S_RESP : S_SEARCH;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SEARCH: begin
					cmp_s1 <= srch_re && !hit;
					if (hit) begin
						state_q <= S_UPD_RD;
					end else if (!srch_re && !cmp_s1) begin
						if (used_q == FULL_CNT) begin
							state_q <= S_RESP;
						end else begin
							used_q  <= used_q + UW'(1);
							state_q <= S_UPD_RD;
						end
					end
				end
				S_UPD_RD: state_q <= S_UPD_WR;
				S_UPD_WR: state_q <= S_RESP;
				S_RD_RD:  state_q <= S_RD_VAL;
				S_RD_VAL: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q   <= in_key;
				frm_q   <= in_frm;
				ri_q    <= s_tdata[213:208];
				rsel_q  <= s_tdata[217:214];
				ptr_q   <= '0;
				res_idx_q <= '0;
				res_new_q <= 1'b0;
				res_val_q <= '0;
				case (s_tuser)
					wlst_pkg::REQ_CLEAR: begin
						res_sts_q <= wlst_pkg::STS_CLEARED;
						res_dir_q <= '0;
					end
					wlst_pkg::REQ_FRAME: begin
						res_sts_q <= wlst_pkg::STS_FILTERED;
						res_dir_q <= in_key.dir;
					end
					default: begin
						res_sts_q <= wlst_pkg::STS_FILTERED;
						res_dir_q <= '0;
					end
				endcase
			end
			S_SEARCH: begin
				addr_s1 <= AW'(ptr_q);
				if (srch_re) begin
					ptr_q <= ptr_q + UW'(1);
				end
				if (hit) begin
					slot_q  <= addr_s1;
					fresh_q <= 1'b0;
				end else if (!srch_re && !cmp_s1) begin
					slot_q    <= AW'(used_q);
					fresh_q   <= 1'b1;
					res_sts_q <= wlst_pkg::STS_FULL;
				end
			end
			S_UPD_WR: begin
				res_sts_q <= wlst_pkg::STS_UPDATED;
				res_idx_q <= 6'(slot_q);
				res_new_q <= fresh_q;
			end
			S_RD_RD: begin
				rd_ok_q <= ri_ok;
			end
			S_RD_VAL: begin
				res_sts_q <= wlst_pkg::STS_READ;
				res_idx_q <= ri_q;
				res_dir_q <= rd_ok_q ? key_rd.dir : 2'd0;
				res_val_q <= rd_ok_q ? sel_val : 48'd0;
			end
			default: begin
			end
		endcase
		if (state_q == S_RESP && out_free) begin
			out_sts_q <= res_sts_q;
			out_idx_q <= res_idx_q;
			out_new_q <= res_new_q;
			out_dir_q <= res_dir_q;
			out_val_q <= res_val_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_sts_q;
	assign m_tdata  = {7'd0, out_val_q, out_dir_q, out_new_q, out_idx_q};

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_CNT)
		else $error("fill count beyond table size");

	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (state_q == S_UPD_WR) && fresh_q)
		else $error("key write outside allocation");

	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && !hit && !srch_re && !cmp_s1 && used_q != FULL_CNT)
		|=> used_q == $past(used_q) + UW'(1))
		else $error("allocation did not advance fill count");

	a_hit_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && hit) |=> state_q == S_UPD_RD && !fresh_q)
		else $error("hit did not go to update");

endmodule

>>> src/wlst_ram.sv
// generic single-port-write, registered-read ram
module wlst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/wlst_update.sv
// counter record update for one accepted frame
module wlst_update (
	input  wlst_pkg::cnt_t base,
	input  logic           fresh,
	input  wlst_pkg::frm_t frm,
	output wlst_pkg::cnt_t upd
);

	wlst_pkg::cnt_t b;

	always_comb begin
		b = fresh ? '0 : base;
		upd = b;
		upd.packets  = b.packets + 32'd1;
		upd.signal   = b.signal + 32'(frm.rssi);
		upd.noise    = b.noise + 32'(frm.noise);
		upd.retries  = b.retries + 32'(frm.retry);
		upd.last_seq = frm.seq;
		case (frm.ftype)
			wlst_pkg::FT_MGMT: begin
				upd.mgmt = b.mgmt + 32'd1;
				if (frm.sub == wlst_pkg::SUB_DISASSOC) begin
					upd.disassoc = b.disassoc + 32'd1;
				end else if (frm.sub == wlst_pkg::SUB_DEAUTH) begin
					upd.deauth = b.deauth + 32'd1;
				end
			end
			wlst_pkg::FT_CTRL: begin
				upd.control = b.control + 32'd1;
			end
			wlst_pkg::FT_DATA: begin
				upd.data  = b.data + 32'd1;
				upd.bytes = b.bytes + 32'(frm.len);
			end
			default: begin
			end
		endcase
	end

endmodule
